// ===== hdl/crcc_pkg.sv =====
// ----------------------------------------------------------------------------
// crcc_pkg
// shared constants and the lfsr step for the ones-prefix crc checker
// ----------------------------------------------------------------------------
package crcc_pkg;

    localparam int MAX_CRC_BITS   = 24;
    localparam int MAX_BLOCK_BITS = 4096;
    localparam int PREFIX_ONES    = 24;

    localparam int CRC_W   = MAX_CRC_BITS;
    localparam int LEN_W   = 5;
    localparam int BLEN_W  = 12;
    localparam int GEN_W   = 25;
    localparam int IDX_W   = $clog2(2 * MAX_BLOCK_BITS);
    localparam int PCNT_W  = $clog2(PREFIX_ONES + 1);
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 25;

    localparam logic [IDX_W-1:0]  IDX_SAT  = IDX_W'(2 * MAX_BLOCK_BITS - 1);
    localparam logic [PCNT_W-1:0] PCNT_END = PCNT_W'(PREFIX_ONES);

    typedef enum logic [CFG_A_W-1:0] {
        REG_BLOCK_LENGTH  = 2'd0,
        REG_CRC_LENGTH    = 2'd1,
        REG_GENERATOR     = 2'd2,
        REG_SCRAMBLE_MASK = 2'd3
    } cfg_reg_t;

    // effective crc length, clipped to the lfsr width
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        eff_len = (len > LEN_W'(MAX_CRC_BITS)) ? LEN_W'(MAX_CRC_BITS) : len;
    endfunction

    // ones in the low len bits
    function automatic logic [CRC_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        len_mask = ~({CRC_W{1'b1}} << len);
    endfunction

    // one bit through the lfsr of length len
    function automatic logic [CRC_W-1:0] lfsr_step(
        input logic [CRC_W-1:0] rem,
        input logic             din,
        input logic [LEN_W-1:0] len,
        input logic [GEN_W-1:0] gen
    );
        logic [CRC_W-1:0] m;
        logic             top;
        logic [CRC_W-1:0] r;
        m   = len_mask(len);
        top = (len == '0) ? 1'b0 : rem[len - LEN_W'(1)];
        r   = (rem << 1) & m;
        if ((din ^ top) && (len != '0)) begin
            r = r ^ (gen[CRC_W-1:0] & m);
        end
        lfsr_step = r;
    endfunction

endpackage

// ===== hdl/crc_check_ones_prefix_rnti.sv =====
// ----------------------------------------------------------------------------
// crc_check_ones_prefix_rnti
// bit-serial crc check with a virtual ones prefix and rnti-scrambled parity
// ----------------------------------------------------------------------------
// a result beat is registered from the beat marked tlast, in the output register or the skid entry
// throughput: one received bit per cycle while s_tready is high, set by the single-step lfsr update
// reset and every configuration write start a prefix pass of twenty-four ones (one lfsr
// step per cycle) during which s_tready is low; config writes are still taken
// aresetn is synchronous, active low; it restores the default registers
module crc_check_ones_prefix_rnti (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [crcc_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [crcc_pkg::CFG_D_W-1:0] cfg_wdata,
    // received bits
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] rx_bit, [7:1] zero
    input  logic        s_tlast,   // frame_end
    // check results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] crc_fail, [24:1] computed_parity, [31:25] zero
);

    localparam int CRC_W  = crcc_pkg::CRC_W;
    localparam int LEN_W  = crcc_pkg::LEN_W;
    localparam int BLEN_W = crcc_pkg::BLEN_W;
    localparam int GEN_W  = crcc_pkg::GEN_W;
    localparam int IDX_W  = crcc_pkg::IDX_W;
    localparam int PCNT_W = crcc_pkg::PCNT_W;
    localparam int RES_W  = CRC_W + 1;

    // configuration registers
    logic [BLEN_W-1:0] block_length_reg;
    logic [LEN_W-1:0]  crc_length_reg;
    logic [GEN_W-1:0]  generator_reg;
    logic [CRC_W-1:0]  scramble_mask_reg;

    // prefix pass
    logic [PCNT_W-1:0] pre_cnt_reg, pre_cnt_next;
    logic [CRC_W-1:0]  pre_rem_reg, pre_rem_next;
    logic              pre_busy;

    // per-block state
    logic [CRC_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [CRC_W-1:0]  rx_par_reg, rx_par_next;

    // output register plus skid entry
    logic              out_vld_reg, out_vld_next;
    logic [RES_W-1:0]  out_dat_reg, out_dat_next;
    logic              skid_vld_reg, skid_vld_next;
    logic [RES_W-1:0]  skid_dat_reg, skid_dat_next;

    logic              s_acc;
    logic              m_acc;
    logic [LEN_W-1:0]  len;
    logic [CRC_W-1:0]  lmask;
    logic [CRC_W-1:0]  rem_src;
    logic [CRC_W-1:0]  rem_upd;
    logic [CRC_W-1:0]  par_upd;
    logic              is_payload;
    logic [CRC_W-1:0]  calc_par;
    logic [RES_W-1:0]  res;
    logic              rx_bit;

    assign len      = crcc_pkg::eff_len(crc_length_reg);
    assign lmask    = crcc_pkg::len_mask(len);
    assign pre_busy = (pre_cnt_reg != crcc_pkg::PCNT_END);
    assign rx_bit   = s_tdata[0];

    assign s_tready = !pre_busy && !skid_vld_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_acc    = out_vld_reg && m_tready;
    assign m_tdata  = {{(32 - RES_W){1'b0}}, out_dat_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_length_reg  <= BLEN_W'(64);
            crc_length_reg    <= LEN_W'(24);
            generator_reg     <= GEN_W'(25'h1B2B117);
            scramble_mask_reg <= CRC_W'(24'h00FFFF);
        end else if (cfg_wr_en) begin
            case (crcc_pkg::cfg_reg_t'(cfg_addr))
                crcc_pkg::REG_BLOCK_LENGTH:  block_length_reg  <= cfg_wdata[BLEN_W-1:0];
                crcc_pkg::REG_CRC_LENGTH:    crc_length_reg    <= cfg_wdata[LEN_W-1:0];
                crcc_pkg::REG_GENERATOR:     generator_reg     <= cfg_wdata[GEN_W-1:0];
                crcc_pkg::REG_SCRAMBLE_MASK: scramble_mask_reg <= cfg_wdata[CRC_W-1:0];
                default: ;
            endcase
        end
    end

    // prefix remainder: twenty-four ones through the lfsr, one per cycle
    always_comb begin
        pre_cnt_next = pre_cnt_reg;
        pre_rem_next = pre_rem_reg;
        if (cfg_wr_en) begin
            pre_cnt_next = '0;
            pre_rem_next = '0;
        end else if (pre_busy) begin
            pre_cnt_next = pre_cnt_reg + PCNT_W'(1);
            pre_rem_next = crcc_pkg::lfsr_step(pre_rem_reg, 1'b1, len, generator_reg);
        end
    end

    // bit update: payload goes through the lfsr, parity into the shift register
    always_comb begin
        rem_src    = (bit_idx_reg == '0) ? pre_rem_reg : rem_reg;
        is_payload = ({1'b0, bit_idx_reg} + (IDX_W + 1)'(len))
                     < (IDX_W + 1)'(block_length_reg);
        rem_upd    = is_payload ? crcc_pkg::lfsr_step(rem_src, rx_bit, len, generator_reg)
                                : rem_src;
        par_upd    = is_payload ? rx_par_reg
                                : (((rx_par_reg << 1) | CRC_W'(rx_bit)) & lmask);
        calc_par   = (rem_upd ^ scramble_mask_reg) & lmask;
        res        = {calc_par, (calc_par != par_upd)};

        rem_next    = rem_reg;
        bit_idx_next = bit_idx_reg;
        rx_par_next = rx_par_reg;
        if (s_acc) begin
            rem_next = rem_upd;
            if (s_tlast) begin
                bit_idx_next = '0;
                rx_par_next  = '0;
            end else begin
                bit_idx_next = (bit_idx_reg == crcc_pkg::IDX_SAT) ? bit_idx_reg
                                                                   : bit_idx_reg + IDX_W'(1);
                rx_par_next  = par_upd;
            end
        end
    end

    // result hand-off: output register, skid entry when it is still held
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_dat_next  = out_dat_reg;
        skid_vld_next = skid_vld_reg;
        skid_dat_next = skid_dat_reg;
        if (m_acc) begin
            out_vld_next  = skid_vld_reg;
            out_dat_next  = skid_dat_reg;
            skid_vld_next = 1'b0;
        end
        if (s_acc && s_tlast) begin
            if (!out_vld_reg || m_acc) begin
                if (m_acc && skid_vld_reg) begin
                    skid_vld_next = 1'b1;
                    skid_dat_next = res;
                end else begin
                    out_vld_next = 1'b1;
                    out_dat_next = res;
                end
            end else begin
                skid_vld_next = 1'b1;
                skid_dat_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_cnt_reg  <= '0;
            pre_rem_reg  <= '0;
            bit_idx_reg  <= '0;
            rx_par_reg   <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            pre_cnt_reg  <= pre_cnt_next;
            pre_rem_reg  <= pre_rem_next;
            bit_idx_reg  <= bit_idx_next;
            rx_par_reg   <= rx_par_next;
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        out_dat_reg  <= out_dat_next;
        skid_dat_reg <= skid_dat_next;
    end

endmodule
